// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/tpta_pkg.sv -----
// Package: widths, register indexes and helpers for the track acceptance block
package tpta_pkg;
  localparam int LENGTH_BITS_DEFAULT = 20;
  localparam int LENGTH_CAP = 28;
  localparam int GAP_BITS = 16;
  localparam int REG_IDX_BITS = 3;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_EDGE_A,
    REG_WIDTH_A,
    REG_GAP_A,
    REG_EDGE_B,
    REG_WIDTH_B,
    REG_ZBOT_B,
    REG_GAP_B,
    REG_DETECT
  } reg_idx_t;

  function automatic int len_bits(int n);
    return (n > LENGTH_CAP) ? LENGTH_CAP : n;
  endfunction

  function automatic int z_bits(int lb);
    return ((lb > GAP_BITS + 1) ? lb : GAP_BITS + 1) + 2;
  endfunction

  function automatic int p_bits(int lb);
    return lb + z_bits(lb) + 6;
  endfunction

  function automatic int cfg_bits(int n);
    return (len_bits(n) > GAP_BITS) ? len_bits(n) : GAP_BITS;
  endfunction

  function automatic int in_tdata_bits(int n);
    return ((len_bits(n) + 7) / 8) * 8;
  endfunction

  function automatic int out_tdata_bits(int n);
    return ((len_bits(n) + 6) / 8) * 8;
  endfunction
endpackage

// ----- hw/rtl/tpta_geom.sv -----
// Band-limit pipeline: slope numerator, scaled face limits, intersection width
module tpta_geom #(
  parameter int LB = tpta_pkg::len_bits(tpta_pkg::LENGTH_BITS_DEFAULT)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LB-1:0]               pos_diff,
  input  logic [LB-1:0]               edge_a,
  input  logic [LB-2:0]               width_a,
  input  logic [tpta_pkg::GAP_BITS-1:0] gap_a,
  input  logic [LB-1:0]               edge_b,
  input  logic [LB-2:0]               width_b,
  input  logic [LB-2:0]               zbot_b,
  input  logic [tpta_pkg::GAP_BITS-1:0] gap_b,
  input  logic [1:0]                  detect,
  output logic                        out_valid,
  output logic [tpta_pkg::p_bits(LB)-1:0] num,
  output logic [tpta_pkg::z_bits(LB)-1:0] den,
  output logic                        pos,
  output logic                        bad
);
  localparam int ZW = tpta_pkg::z_bits(LB);
  localparam int NW = LB + 3;
  localparam int PW = tpta_pkg::p_bits(LB);

  // stage 1
  logic signed [LB-1:0] pd_s, ea_s, eb_s;
  logic signed [ZW-1:0] za, zd, zabs;
  logic signed [NW-1:0] n_c;
  logic                 v1, b1;
  logic signed [NW-1:0] n1;
  logic [ZW-1:0]        d1;

  assign pd_s = pos_diff;
  assign ea_s = edge_a;
  assign eb_s = edge_b;

  always_comb begin
    za = detect[0] ? $signed(ZW'(gap_a)) : '0;
    zd = $signed(ZW'(zbot_b)) + (detect[1] ? $signed(ZW'(gap_b)) : $signed(ZW'(0))) - za;
    zabs = (zd < 0) ? -zd : zd;
    n_c = (NW'(pd_s) <<< 1) + (NW'(eb_s) <<< 1) + $signed(NW'(width_b))
        - (NW'(ea_s) <<< 1) - $signed(NW'(width_a));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      n1 <= (zd < 0) ? -n_c : n_c;
      d1 <= {zabs[ZW-2:0], 1'b0};
      b1 <= (zd == '0);
    end
  end

  // stage 2
  logic signed [ZW:0]    ds, fz1, fz2, fz3;
  logic signed [LB-1:0]  wa_s, wb_s;
  logic signed [LB+ZW:0] pea_c, peb_c, pwa_c, pwb_c;
  logic signed [NW+ZW:0] m1_c, m2_c, m3_c;
  logic                  v2, b2;
  logic [ZW-1:0]         d2;
  logic signed [LB+ZW:0] p_ea, p_eb, p_wa, p_wb;
  logic signed [NW+ZW:0] m1, m2, m3;

  assign ds   = $signed({1'b0, d1});
  assign wa_s = $signed({1'b0, width_a});
  assign wb_s = $signed({1'b0, width_b});
  assign fz1  = $signed({1'b0, ZW'(gap_a)});
  assign fz2  = $signed({1'b0, ZW'(zbot_b)});
  assign fz3  = fz2 + $signed({1'b0, ZW'(gap_b)});
  assign pea_c = ea_s * ds;
  assign peb_c = eb_s * ds;
  assign pwa_c = wa_s * ds;
  assign pwb_c = wb_s * ds;
  assign m1_c  = n1 * fz1;
  assign m2_c  = n1 * fz2;
  assign m3_c  = n1 * fz3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      p_ea <= pea_c;
      p_eb <= peb_c;
      p_wa <= pwa_c;
      p_wb <= pwb_c;
      m1   <= m1_c;
      m2   <= m2_c;
      m3   <= m3_c;
      d2   <= d1;
      b2   <= b1;
    end
  end

  // stage 3
  logic signed [PW-1:0] lo_c [4];
  logic signed [PW-1:0] hi_c [4];
  logic signed [PW-1:0] lo [4];
  logic signed [PW-1:0] hi [4];
  logic                 v3, b3;
  logic [ZW-1:0]        d3;

  always_comb begin
    lo_c[0] = PW'(p_ea);
    lo_c[1] = PW'(p_ea) - PW'(m1);
    lo_c[2] = PW'(p_eb) - PW'(m2);
    lo_c[3] = PW'(p_eb) - PW'(m3);
    hi_c[0] = lo_c[0] + PW'(p_wa);
    hi_c[1] = lo_c[1] + PW'(p_wa);
    hi_c[2] = lo_c[2] + PW'(p_wb);
    hi_c[3] = lo_c[3] + PW'(p_wb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      lo <= lo_c;
      hi <= hi_c;
      d3 <= d2;
      b3 <= b2;
    end
  end

  // stage 4
  logic signed [PW-1:0] mx01, mx23, mn01, mn23, mx, mn;
  logic                 v4, b4;
  logic [ZW-1:0]        d4;

  always_comb begin
    mx01 = (lo[1] > lo[0]) ? lo[1] : lo[0];
    mx23 = (lo[3] > lo[2]) ? lo[3] : lo[2];
    mn01 = (hi[1] < hi[0]) ? hi[1] : hi[0];
    mn23 = (hi[3] < hi[2]) ? hi[3] : hi[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      mx <= (mx23 > mx01) ? mx23 : mx01;
      mn <= (mn23 < mn01) ? mn23 : mn01;
      d4 <= d3;
      b4 <= b3;
    end
  end

  // stage 5
  logic signed [PW-1:0] diff;

  assign diff = mn - mx;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v4;
    end
    if (en) begin
      num <= diff + $signed(PW'(d4 >> 1));
      den <= d4;
      pos <= (diff > 0) && !b4;
      bad <= b4;
    end
  end
endmodule

// ----- hw/rtl/tpta_div.sv -----
// Pipelined restoring divider with round-to-nearest numerator and saturation
module tpta_div #(
  parameter int LB = tpta_pkg::len_bits(tpta_pkg::LENGTH_BITS_DEFAULT)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [tpta_pkg::p_bits(LB)-1:0] num,
  input  logic [tpta_pkg::z_bits(LB)-1:0] den,
  input  logic                            pos,
  input  logic                            bad,
  output logic                            out_valid,
  output logic [LB-2:0]                   len,
  output logic                            out_bad
);
  localparam int ZW = tpta_pkg::z_bits(LB);
  localparam int PW = tpta_pkg::p_bits(LB);
  localparam int QW = LB - 1;

  logic [PW-1:0] rem  [QW];
  logic [ZW-1:0] dv   [QW];
  logic [QW-1:0] quo  [QW+1];
  logic          sat  [QW+1];
  logic          zero [QW+1];
  logic          bd   [QW+1];
  logic          v    [QW+1];

  // stage 0: saturation check
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      rem[0]  <= num;
      dv[0]   <= den;
      quo[0]  <= '0;
      sat[0]  <= pos && (num >= (PW'(den) << QW));
      zero[0] <= !pos;
      bd[0]   <= bad;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 1; j <= QW; j++) begin : g_stage
    localparam int K = QW - j;
    logic [PW-1:0] trial;
    logic          ge;

    assign trial = PW'(dv[j-1]) << K;
    assign ge    = (rem[j-1] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en) begin
        v[j] <= v[j-1];
      end
      if (en) begin
        quo[j]  <= {quo[j-1][QW-2:0], ge};
        sat[j]  <= sat[j-1];
        zero[j] <= zero[j-1];
        bd[j]   <= bd[j-1];
      end
    end

    if (j < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j] <= ge ? (rem[j-1] - trial) : rem[j-1];
          dv[j]  <= dv[j-1];
        end
      end
    end
  end

  assign out_valid = v[QW];
  assign out_bad   = bd[QW];
  assign len       = sat[QW] ? '1 : (zero[QW] ? '0 : quo[QW]);
endmodule

// ----- hw/rtl/two_plane_track_acceptance.sv -----
// Top level: config registers, band pipeline, divider and output skid stage
// Pipeline: five band stages, LB divider stages and the output register.
// Throughput: one word per cycle; the pipeline stalls only while the skid holds a word.
// Reset: synchronous, clears all config registers to zero and empties the pipeline.
`include "assert_macros.svh"

module two_plane_track_acceptance #(
  parameter int LENGTH_BITS = tpta_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          cfg_we,
  input  logic [tpta_pkg::REG_IDX_BITS-1:0]             cfg_index,
  input  logic [tpta_pkg::cfg_bits(LENGTH_BITS)-1:0]    cfg_data,
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  input  logic [tpta_pkg::in_tdata_bits(LENGTH_BITS)-1:0]  s_tdata,  // pos_diff
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  output logic [tpta_pkg::out_tdata_bits(LENGTH_BITS)-1:0] m_tdata, // effective_length
  output logic [0:0]                                    m_tuser   // bad_geometry
);
  localparam int LB  = tpta_pkg::len_bits(LENGTH_BITS);
  localparam int ZW  = tpta_pkg::z_bits(LB);
  localparam int PW  = tpta_pkg::p_bits(LB);
  localparam int GB  = tpta_pkg::GAP_BITS;
  localparam int OTW = tpta_pkg::out_tdata_bits(LENGTH_BITS);

  logic [LB-1:0] edge_a, edge_b;
  logic [LB-2:0] width_a, width_b, zbot_b;
  logic [GB-1:0] gap_a, gap_b;
  logic [1:0]    detect;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_a  <= '0;
      width_a <= '0;
      gap_a   <= '0;
      edge_b  <= '0;
      width_b <= '0;
      zbot_b  <= '0;
      gap_b   <= '0;
      detect  <= '0;
    end else if (cfg_we) begin
      unique case (tpta_pkg::reg_idx_t'(cfg_index))
        tpta_pkg::REG_EDGE_A:  edge_a  <= cfg_data[LB-1:0];
        tpta_pkg::REG_WIDTH_A: width_a <= cfg_data[LB-2:0];
        tpta_pkg::REG_GAP_A:   gap_a   <= cfg_data[GB-1:0];
        tpta_pkg::REG_EDGE_B:  edge_b  <= cfg_data[LB-1:0];
        tpta_pkg::REG_WIDTH_B: width_b <= cfg_data[LB-2:0];
        tpta_pkg::REG_ZBOT_B:  zbot_b  <= cfg_data[LB-2:0];
        tpta_pkg::REG_GAP_B:   gap_b   <= cfg_data[GB-1:0];
        tpta_pkg::REG_DETECT:  detect  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic          en;
  logic          g_valid, g_pos, g_bad;
  logic [PW-1:0] g_num;
  logic [ZW-1:0] g_den;
  logic          p_valid, p_bad;
  logic [LB-2:0] p_len;

  logic          out_valid, out_bad, skid_valid, skid_bad;
  logic [LB-2:0] out_len, skid_len;

  assign en       = !skid_valid;
  assign s_tready = en;

  tpta_geom #(.LB(LB)) u_geom (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .pos_diff (s_tdata[LB-1:0]),
    .edge_a   (edge_a),
    .width_a  (width_a),
    .gap_a    (gap_a),
    .edge_b   (edge_b),
    .width_b  (width_b),
    .zbot_b   (zbot_b),
    .gap_b    (gap_b),
    .detect   (detect),
    .out_valid(g_valid),
    .num      (g_num),
    .den      (g_den),
    .pos      (g_pos),
    .bad      (g_bad)
  );

  tpta_div #(.LB(LB)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (g_valid),
    .num      (g_num),
    .den      (g_den),
    .pos      (g_pos),
    .bad      (g_bad),
    .out_valid(p_valid),
    .len      (p_len),
    .out_bad  (p_bad)
  );

  // output register with one-word skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (p_valid) begin
      if (!out_valid || m_tready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_tready) begin
        out_len <= skid_len;
        out_bad <= skid_bad;
      end
    end else if (p_valid) begin
      if (!out_valid || m_tready) begin
        out_len <= p_len;
        out_bad <= p_bad;
      end else begin
        skid_len <= p_len;
        skid_bad <= p_bad;
      end
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = OTW'(out_len);
  assign m_tuser[0] = out_bad;

  `ASSERT_IMPLY(a_skid_needs_out, clk, rst, skid_valid, out_valid)
  `ASSERT_IMPLY(a_bad_gives_zero, clk, rst, out_valid && out_bad, out_len == '0)
  `ASSERT_NEXT(a_skid_holds, clk, rst, skid_valid && !m_tready,
               skid_valid && $stable(skid_len) && $stable(skid_bad))
endmodule

// ----- tb/tb_top.sv -----
// Testbench for two_plane_track_acceptance: directed cases and random geometry phases with checked acceptance widths
module tb_top;
  localparam int LB = 20;
  localparam int CW = tpta_pkg::cfg_bits(LB);
  localparam int IW = tpta_pkg::in_tdata_bits(LB);
  localparam int OW = tpta_pkg::out_tdata_bits(LB);
  localparam int LATENCY = LB + 6;
  localparam longint LIMIT = 2000000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [tpta_pkg::REG_IDX_BITS-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OW-1:0] m_tdata;
  logic [0:0] m_tuser;

  typedef struct packed {
    logic [LB-2:0] length;
    logic          bad;
  } accept_t;

  logic [LB-1:0] diff_q[$];
  accept_t       accept_q[$];
  int            errors = 0;
  longint        cycles = 0;

  // shadow geometry registers
  logic signed [LB-1:0] g_edge_a, g_edge_b;
  logic [LB-2:0]        g_width_a, g_width_b, g_zbot_b;
  logic [15:0]          g_gap_a, g_gap_b;
  logic [1:0]           g_detect;

  two_plane_track_acceptance #(.LENGTH_BITS(LB)) u_top (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic accept_t acceptance_width(logic [LB-1:0] pdw);
    longint ea, wa, ga, eb, wb, zb, gb, pd, za, zd, num2, den, lo, hi, maxlo, minhi, d, q;
    longint fz[4], fe[4], fw[4];
    accept_t r;
    ea = longint'(g_edge_a); wa = g_width_a; ga = g_gap_a;
    eb = longint'(g_edge_b); wb = g_width_b; zb = g_zbot_b; gb = g_gap_b;
    pd = longint'(signed'(pdw));
    za = g_detect[0] ? ga : 0;
    zd = zb + (g_detect[1] ? gb : 0) - za;
    if (zd == 0) begin
      r.length = '0; r.bad = 1;
      return r;
    end
    num2 = 2*pd + 2*eb + wb - 2*ea - wa;
    den = 2*zd;
    if (den < 0) begin
      den = -den; num2 = -num2;
    end
    fz[0] = 0; fz[1] = ga; fz[2] = zb; fz[3] = zb + gb;
    fe[0] = ea; fe[1] = ea; fe[2] = eb; fe[3] = eb;
    fw[0] = wa; fw[1] = wa; fw[2] = wb; fw[3] = wb;
    maxlo = 0; minhi = 0;
    for (int i = 0; i < 4; i++) begin
      lo = fe[i]*den - num2*fz[i];
      hi = lo + fw[i]*den;
      if (i == 0 || lo > maxlo) maxlo = lo;
      if (i == 0 || hi < minhi) minhi = hi;
    end
    d = minhi - maxlo;
    q = 0;
    if (d > 0) begin
      q = (d + den/2) / den;
      if (q > (1 << (LB-1)) - 1) q = (1 << (LB-1)) - 1;
    end
    r.length = q[LB-2:0]; r.bad = 0;
    return r;
  endfunction

  task automatic report(string what, logic [OW-1:0] got, logic [OW-1:0] want);
    errors++;
    $display("mismatch %s: got %0d want %0d", what, got, want);
  endtask

  task automatic write_reg(tpta_pkg::reg_idx_t idx, logic [CW-1:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      tpta_pkg::REG_EDGE_A:  g_edge_a  = val[LB-1:0];
      tpta_pkg::REG_WIDTH_A: g_width_a = val[LB-2:0];
      tpta_pkg::REG_GAP_A:   g_gap_a   = val[15:0];
      tpta_pkg::REG_EDGE_B:  g_edge_b  = val[LB-1:0];
      tpta_pkg::REG_WIDTH_B: g_width_b = val[LB-2:0];
      tpta_pkg::REG_ZBOT_B:  g_zbot_b  = val[LB-2:0];
      tpta_pkg::REG_GAP_B:   g_gap_b   = val[15:0];
      tpta_pkg::REG_DETECT:  g_detect  = val[1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (diff_q.size() != 0 || accept_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [LB-1:0] pick_diff(int mode);
    case (mode)
      0: return LB'($urandom);
      1: return LB'($urandom_range(0, 400) - 200);
      default: return LB'($urandom_range(0, 40000) - 20000);
    endcase
  endfunction

  task automatic geometry(int kind);
    int span;
    span = (kind == 0) ? (1 << 19) - 1 : (kind == 1) ? 4000 : 60000;
    write_reg(tpta_pkg::REG_EDGE_A,
              (kind == 0) ? CW'($urandom) : CW'($urandom_range(0, 2*span) - span));
    write_reg(tpta_pkg::REG_WIDTH_A, CW'($urandom_range(0, span)));
    write_reg(tpta_pkg::REG_GAP_A,
              (kind == 0) ? CW'($urandom) : CW'($urandom_range(0, 300)));
    write_reg(tpta_pkg::REG_EDGE_B,
              (kind == 0) ? CW'($urandom) : CW'($urandom_range(0, 2*span) - span));
    write_reg(tpta_pkg::REG_WIDTH_B, CW'($urandom_range(0, span)));
    write_reg(tpta_pkg::REG_ZBOT_B,
              (kind == 0) ? CW'($urandom) : CW'($urandom_range(0, 2000)));
    write_reg(tpta_pkg::REG_GAP_B,
              (kind == 0) ? CW'($urandom) : CW'($urandom_range(0, 300)));
    write_reg(tpta_pkg::REG_DETECT, CW'($urandom_range(0, 3)));
  endtask

  // driver
  int s_wait = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        accept_q.push_back(acceptance_width(s_tdata[LB-1:0]));
        void'(diff_q.pop_front());
        s_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
      end
      if (s_wait > 0) begin
        s_wait--;
        s_tvalid <= 0;
      end else if (diff_q.size() != 0) begin
        s_tdata <= {{(IW-LB){$urandom_range(0, 1) == 1}}, diff_q[0]};
        s_tvalid <= 1;
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // monitor
  int m_wait = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (accept_q.size() == 0) begin
          report("unexpected word", m_tdata, '0);
        end else begin
          accept_t e;
          e = accept_q.pop_front();
          if (m_tdata !== OW'(e.length)) report("effective_length", m_tdata, OW'(e.length));
          if (m_tuser[0] !== e.bad) report("bad_geometry", OW'(m_tuser), OW'(e.bad));
        end
        m_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
      end
      if (m_wait > 0) begin
        m_wait--;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  initial begin
    g_edge_a = 0; g_edge_b = 0; g_width_a = 0; g_width_b = 0;
    g_zbot_b = 0; g_gap_a = 0; g_gap_b = 0; g_detect = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    // reset geometry: planes coincide
    diff_q.push_back(20'd0);
    drain();
    // directed: extremes and special cases
    write_reg(tpta_pkg::REG_EDGE_A, CW'(-1000));
    write_reg(tpta_pkg::REG_WIDTH_A, CW'(2000));
    write_reg(tpta_pkg::REG_GAP_A, CW'(100));
    write_reg(tpta_pkg::REG_EDGE_B, CW'(-1000));
    write_reg(tpta_pkg::REG_WIDTH_B, CW'(2000));
    write_reg(tpta_pkg::REG_ZBOT_B, CW'(500));
    write_reg(tpta_pkg::REG_GAP_B, CW'(100));
    write_reg(tpta_pkg::REG_DETECT, CW'(3));
    diff_q.push_back(20'h00000); diff_q.push_back(20'h80000); diff_q.push_back(20'h7FFFF);
    diff_q.push_back(20'hFFFFF); diff_q.push_back(20'd1); diff_q.push_back(20'd100);
    diff_q.push_back(-20'sd100); diff_q.push_back(20'd4000); diff_q.push_back(20'd3999);
    drain();
    // coinciding planes: A top at B bottom
    write_reg(tpta_pkg::REG_ZBOT_B, CW'(100));
    write_reg(tpta_pkg::REG_DETECT, CW'(1));
    diff_q.push_back(20'd5);
    drain();
    // huge widths: coinciding planes first, then reversed planes
    write_reg(tpta_pkg::REG_ZBOT_B, CW'(0));
    write_reg(tpta_pkg::REG_GAP_A, CW'(16'hFFFF));
    write_reg(tpta_pkg::REG_WIDTH_A, CW'(19'h7FFFF));
    write_reg(tpta_pkg::REG_WIDTH_B, CW'(19'h7FFFF));
    write_reg(tpta_pkg::REG_EDGE_A, CW'(20'h80000));
    write_reg(tpta_pkg::REG_EDGE_B, CW'(20'h80000));
    write_reg(tpta_pkg::REG_GAP_B, CW'(16'hFFFF));
    write_reg(tpta_pkg::REG_DETECT, CW'(0));
    diff_q.push_back(20'd0); diff_q.push_back(20'h7FFFF); diff_q.push_back(20'h80000);
    drain();
    write_reg(tpta_pkg::REG_DETECT, CW'(1));
    diff_q.push_back(20'd0); diff_q.push_back(20'h12345);
    drain();
    write_reg(tpta_pkg::REG_EDGE_A, CW'(20'h7FFFF));
    write_reg(tpta_pkg::REG_ZBOT_B, CW'(19'h7FFFF));
    diff_q.push_back(20'd0); diff_q.push_back(20'h80000);
    drain();
    // random phases
    for (int p = 0; p < 26; p++) begin
      int mode;
      mode = $urandom_range(0, 2);
      geometry(mode);
      for (int k = 0; k < 50; k++) diff_q.push_back(pick_diff(mode == 0 ? 0 : $urandom_range(0, 2)));
      drain();
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ----- two_plane_track_acceptance.f -----
+incdir+hw/rtl
hw/rtl/tpta_pkg.sv
hw/rtl/tpta_geom.sv
hw/rtl/tpta_div.sv
hw/rtl/two_plane_track_acceptance.sv
tb/tb_top.sv
